[hw/rtl/rodrigues_rotate_with_matrix_defines.svh]
// assertion macros used by the top-level rtl file
`ifndef RODRIGUES_ROTATE_WITH_MATRIX_DEFINES_SVH
`define RODRIGUES_ROTATE_WITH_MATRIX_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rrm_pkg.sv]
package rrm_pkg;

    localparam int FRONT_LAT = 2;
    localparam int SQRT_LAT  = 32;
    localparam int DIV_LAT   = 31;
    localparam int COR_LAT   = 34;
    localparam int MAT_LAT   = 5;
    localparam int LAT       = FRONT_LAT + SQRT_LAT + COR_LAT + MAT_LAT;
    localparam int COR_STEPS = 30;
    localparam int COR_W     = 34;

    localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;
    localparam logic signed [COR_W-1:0] ONE_C = 34'sd1073741824;
    localparam logic signed [COR_W-1:0] GAIN_C = 34'sd652032874;
    localparam logic [31:0] TWO_PI_U          = 32'd1686629713;
    localparam logic signed [32:0] TWO_PI_S   = 33'sd1686629713;
    localparam logic signed [32:0] PI_S       = 33'sd843314857;
    localparam logic signed [32:0] HALF_PI_S  = 33'sd421657428;

    // arctangent of 2^-i in q2.30
    function automatic logic signed [COR_W-1:0] atan_q30(input int i);
        logic signed [COR_W-1:0] t;
        unique case (i)
            0: t = 34'sd843314857;
            1: t = 34'sd497837829;
            2: t = 34'sd263043837;
            3: t = 34'sd133525159;
            4: t = 34'sd67021687;
            5: t = 34'sd33543516;
            6: t = 34'sd16775851;
            7: t = 34'sd8388437;
            8: t = 34'sd4194283;
            9: t = 34'sd2097149;
            default: t = $signed({{(COR_W-1){1'b0}}, 1'b1} << (30 - i));
        endcase
        return t;
    endfunction

    // q2.30 product, rounded half up
    function automatic logic signed [33:0] mulq(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        p = p + 66'sd536870912;
        return 34'(p >>> 30);
    endfunction

endpackage

[hw/rtl/rrm_isqrt.sv]
module rrm_isqrt
    import rrm_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    logic [63:0] n_reg [SQRT_LAT];
    logic [63:0] r_reg [SQRT_LAT];

    // one result bit per stage, msb first
    for (genvar s = 0; s < SQRT_LAT; s++) begin : g_step
        localparam int B = 2 * (SQRT_LAT - 1 - s);
        logic [63:0] n_in;
        logic [63:0] r_in;
        logic [63:0] bitv;
        logic [63:0] trial;

        if (s == 0) begin : g_first
            assign n_in = radicand;
            assign r_in = '0;
        end
        else begin : g_rest
            assign n_in = n_reg[s-1];
            assign r_in = r_reg[s-1];
        end

        assign bitv  = 64'd1 << B;
        assign trial = r_in + bitv;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (n_in >= trial)
                begin
                    n_reg[s] <= n_in - trial;
                    r_reg[s] <= (r_in >> 1) + bitv;
                end
                else
                begin
                    n_reg[s] <= n_in;
                    r_reg[s] <= r_in >> 1;
                end
            end
        end
    end

    assign root = r_reg[SQRT_LAT-1][31:0];

endmodule

[hw/rtl/rrm_cordic.sv]
module rrm_cordic
    import rrm_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        theta,
    output logic signed [31:0] cos_q30,
    output logic signed [31:0] sin_q30
);

    logic [31:0]             a1_reg, a1_next;
    logic [31:0]             a2_reg, a2_next;
    logic signed [32:0]      a_wrap, a_fold;
    logic                    neg_next;
    logic signed [COR_W-1:0] x_reg [COR_STEPS+1];
    logic signed [COR_W-1:0] y_reg [COR_STEPS+1];
    logic signed [COR_W-1:0] z_reg [COR_STEPS+1];
    logic                    neg_reg [COR_STEPS+1];
    logic signed [COR_W-1:0] xc, yc;
    logic signed [31:0]      cos_reg, sin_reg;

    // range reduction mod 2pi, at most two subtractions
    assign a1_next = (theta >= TWO_PI_U) ? theta - TWO_PI_U : theta;
    assign a2_next = (a1_reg >= TWO_PI_U) ? a1_reg - TWO_PI_U : a1_reg;

    // fold into [-pi/2, pi/2], a fold through pi flips the cosine
    always_comb
    begin
        a_wrap = $signed({1'b0, a2_reg});
        if (a_wrap > PI_S)
            a_wrap = a_wrap - TWO_PI_S;
        a_fold   = a_wrap;
        neg_next = 1'b0;
        if (a_wrap > HALF_PI_S)
        begin
            a_fold   = PI_S - a_wrap;
            neg_next = 1'b1;
        end
        else if (a_wrap < -HALF_PI_S)
        begin
            a_fold   = -PI_S - a_wrap;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg     <= a1_next;
            a2_reg     <= a2_next;
            x_reg[0]   <= GAIN_C;
            y_reg[0]   <= '0;
            z_reg[0]   <= $signed({a_fold[31:0], 2'b00});
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < COR_STEPS; i++) begin : g_iter
        logic signed [COR_W-1:0] dx, dy, stp;
        assign dx  = y_reg[i] >>> i;
        assign dy  = x_reg[i] >>> i;
        assign stp = atan_q30(i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][COR_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - stp;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + stp;
                end
            end
        end
    end

    always_comb
    begin
        xc = x_reg[COR_STEPS];
        if (xc > ONE_C)
            xc = ONE_C;
        else if (xc < -ONE_C)
            xc = -ONE_C;
        yc = y_reg[COR_STEPS];
        if (yc > ONE_C)
            yc = ONE_C;
        else if (yc < -ONE_C)
            yc = -ONE_C;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= neg_reg[COR_STEPS] ? 32'(-xc) : 32'(xc);
            sin_reg <= 32'(yc);
        end
    end

    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

endmodule

[hw/rtl/rodrigues_rotate_with_matrix.sv]
// channel  | dir | handshake         | payload
// ---------+-----+-------------------+-----------------------------------------
// s_t*     | in  | s_tvalid/s_tready | rot_x, rot_y, rot_z, vec_x, vec_y, vec_z
// m_t*     | out | m_tvalid/m_tready | res_x..res_z, 3x3 matrix by columns
//
// fully pipelined: one transaction per cycle while the output is not stalled
// most of the pipeline depth comes from the 32-stage square root plus the
// 34-stage cordic and the 31-stage restoring dividers that run beside it
// rst_n clears only the valid bits, the datapath needs no reset
// a stall at the output freezes every stage at once and drops input ready,
// so nothing is lost or repeated; ready stays high while the output moves
module rodrigues_rotate_with_matrix
    import rrm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // rot_x, rot_y, rot_z, vec_x, vec_y, vec_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [383:0] m_tdata    // res_x, res_y, res_z, mat_00, mat_10,
                                    // mat_20, mat_01, mat_11, mat_21, mat_02,
                                    // mat_12, mat_22
);

`include "rodrigues_rotate_with_matrix_defines.svh"

    localparam int KD_LAT = COR_LAT - DIV_LAT;
    localparam int M3_IDX = FRONT_LAT + SQRT_LAT + COR_LAT + 2;

    typedef struct packed {
        logic [2:0]  sgn;
        logic        zero;
        logic [95:0] vec;
    } side_t;

    logic             adv;
    logic [LAT-1:0]   vld_reg;

    // stall handling: all stages advance together
    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    // front end: squares, then their sum
    logic signed [31:0] rot_in [3];
    logic signed [31:0] vec_in [3];
    logic signed [31:0] rot1_reg [3];
    logic signed [31:0] vec1_reg [3];
    logic [63:0]        sq1_reg [3];
    logic signed [31:0] rot2_reg [3];
    logic signed [31:0] vec2_reg [3];
    logic [63:0]        th2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rot_in[i] = $signed(s_tdata[32*i +: 32]);
            vec_in[i] = $signed(s_tdata[96 + 32*i +: 32]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rot1_reg[i] <= rot_in[i];
                vec1_reg[i] <= vec_in[i];
                sq1_reg[i]  <= $unsigned(64'(rot_in[i]) * 64'(rot_in[i]));
            end
            rot2_reg <= rot1_reg;
            vec2_reg <= vec1_reg;
            th2_reg  <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
        end
    end

    // angle magnitude
    logic [31:0] th;

    rrm_isqrt u_isqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (th2_reg),
        .root     (th)
    );

    logic signed [31:0] rotd_reg [SQRT_LAT][3];
    logic signed [31:0] vecd_reg [SQRT_LAT][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rotd_reg[0] <= rot2_reg;
            vecd_reg[0] <= vec2_reg;
            for (int d = 1; d < SQRT_LAT; d++)
            begin
                rotd_reg[d] <= rotd_reg[d-1];
                vecd_reg[d] <= vecd_reg[d-1];
            end
        end
    end

    // axis: |rot_i| * 2^30 / theta by restoring division, one quotient bit
    // per stage; |rot_i| never exceeds theta so the quotient fits 31 bits
    logic [31:0] mag [3];
    logic [31:0] den_reg [DIV_LAT];
    logic [31:0] rem_reg [3][DIV_LAT];
    logic [30:0] q_reg [3][DIV_LAT];
    logic [30:0] kd_reg [3][KD_LAT];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            mag[a] = rotd_reg[SQRT_LAT-1][a][31] ?
                     32'(~$unsigned(rotd_reg[SQRT_LAT-1][a]) + 32'd1) :
                     $unsigned(rotd_reg[SQRT_LAT-1][a]);
    end

    for (genvar j = 0; j < DIV_LAT; j++) begin : g_div
        logic [31:0] den_in;
        if (j == 0) begin : g_first
            assign den_in = th;
        end
        else begin : g_rest
            assign den_in = den_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                den_reg[j] <= den_in;
        end

        for (genvar a = 0; a < 3; a++) begin : g_axis
            logic [32:0] cur;
            logic [30:0] q_in;
            logic        ge;
            if (j == 0) begin : g_first
                assign cur  = {1'b0, mag[a]};
                assign q_in = '0;
            end
            else begin : g_rest
                assign cur  = {rem_reg[a][j-1], 1'b0};
                assign q_in = q_reg[a][j-1];
            end
            assign ge = cur >= {1'b0, den_in};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[a][j] <= ge ? 32'(cur - {1'b0, den_in}) : cur[31:0];
                    q_reg[a][j]   <= {q_in[29:0], ge};
                end
            end
        end
    end

    // line the quotients up with the cordic output
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                kd_reg[a][0] <= q_reg[a][DIV_LAT-1];
                for (int d = 1; d < KD_LAT; d++)
                    kd_reg[a][d] <= kd_reg[a][d-1];
            end
        end
    end

    // sine and cosine of theta
    logic signed [31:0] cos_v, sin_v;

    rrm_cordic u_cordic (
        .clk     (clk),
        .en      (adv),
        .theta   (th),
        .cos_q30 (cos_v),
        .sin_q30 (sin_v)
    );

    // signs, zero-vector flag and the vector ride beside the cordic
    side_t side_next;
    side_t side_reg [COR_LAT];

    always_comb
    begin
        side_next.zero = (th == '0);
        for (int a = 0; a < 3; a++)
        begin
            side_next.sgn[a]          = rotd_reg[SQRT_LAT-1][a][31];
            side_next.vec[32*a +: 32] = vecd_reg[SQRT_LAT-1][a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int d = 1; d < COR_LAT; d++)
                side_reg[d] <= side_reg[d-1];
        end
    end

    // matrix stage 1: signed axis, k_i*k_j and k_i*s; zero vector gives identity
    side_t              side_m;
    logic signed [31:0] ks [3];
    logic signed [31:0] cf, sf;
    logic signed [33:0] kk1_reg [3][3];
    logic signed [33:0] u1_reg [3];
    logic signed [31:0] c1_reg;
    logic signed [32:0] omc1_reg;
    side_t              side1_reg;

    assign side_m = side_reg[COR_LAT-1];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (side_m.zero)
                ks[a] = '0;
            else if (side_m.sgn[a])
                ks[a] = -$signed({1'b0, kd_reg[a][KD_LAT-1]});
            else
                ks[a] = $signed({1'b0, kd_reg[a][KD_LAT-1]});
        end
        cf = side_m.zero ? ONE_Q30 : cos_v;
        sf = side_m.zero ? '0 : sin_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u1_reg[i] <= mulq(33'(ks[i]), 33'(sf));
                for (int j = 0; j < 3; j++)
                    kk1_reg[i][j] <= mulq(33'(ks[i]), 33'(ks[j]));
            end
            c1_reg    <= cf;
            omc1_reg  <= 33'(ONE_Q30) - 33'(cf);
            side1_reg <= side_m;
        end
    end

    // matrix stage 2: (k_i*k_j)*(1-c)
    logic signed [33:0] t2_reg [3][3];
    logic signed [33:0] u2_reg [3];
    logic signed [31:0] c2_reg;
    side_t              side2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    t2_reg[i][j] <= mulq(33'(kk1_reg[i][j]), omc1_reg);
            u2_reg    <= u1_reg;
            c2_reg    <= c1_reg;
            side2_reg <= side1_reg;
        end
    end

    // matrix stage 3: add cosine diagonal and skew terms, clamp to [-1, 1]
    logic signed [35:0] msum [3][3];
    logic signed [31:0] m3_reg [3][3];
    side_t              side3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                msum[i][j] = 36'(t2_reg[i][j]);
                if (i == j)
                    msum[i][j] = msum[i][j] + 36'(c2_reg);
            end
        msum[0][1] = msum[0][1] - 36'(u2_reg[2]);
        msum[1][0] = msum[1][0] + 36'(u2_reg[2]);
        msum[0][2] = msum[0][2] + 36'(u2_reg[1]);
        msum[2][0] = msum[2][0] - 36'(u2_reg[1]);
        msum[1][2] = msum[1][2] - 36'(u2_reg[0]);
        msum[2][1] = msum[2][1] + 36'(u2_reg[0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    if (msum[i][j] > 36'(ONE_Q30))
                        m3_reg[i][j] <= ONE_Q30;
                    else if (msum[i][j] < -36'(ONE_Q30))
                        m3_reg[i][j] <= -ONE_Q30;
                    else
                        m3_reg[i][j] <= 32'(msum[i][j]);
                end
            side3_reg <= side2_reg;
        end
    end

    // matrix stage 4: products R_ij * v_j
    logic signed [63:0] p4_reg [3][3];
    logic signed [31:0] m4_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    p4_reg[i][j] <= 64'(m3_reg[i][j]) *
                                    64'($signed(side3_reg.vec[32*j +: 32]));
            m4_reg <= m3_reg;
        end
    end

    // output register: row sums, round half up, saturate
    logic signed [65:0] acc [3];
    logic signed [35:0] shv [3];
    logic signed [31:0] res_reg [3];
    logic signed [31:0] mat_reg [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = 66'(p4_reg[i][0]) + 66'(p4_reg[i][1]) + 66'(p4_reg[i][2])
                   + 66'sd536870912;
            shv[i] = 36'(acc[i] >>> 30);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (shv[i] > 36'sd2147483647)
                    res_reg[i] <= 32'sh7fffffff;
                else if (shv[i] < -36'sd2147483648)
                    res_reg[i] <= 32'sh80000000;
                else
                    res_reg[i] <= 32'(shv[i]);
            end
            mat_reg <= m4_reg;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            m_tdata[32*i +: 32] = res_reg[i];
        for (int j = 0; j < 3; j++)
            for (int i = 0; i < 3; i++)
                m_tdata[96 + 96*j + 32*i +: 32] = mat_reg[i][j];
    end

    // a held output must freeze the whole valid chain
    `RRM_ASSERT_NEXT(a_stall_freeze, !adv, $stable(vld_reg), "valid chain moved in a stall")
    // a zero rotation vector must give the identity matrix
    `RRM_ASSERT_NOW(a_zero_ident, vld_reg[M3_IDX] && side3_reg.zero, m3_reg[0][0] == ONE_Q30 && m3_reg[1][1] == ONE_Q30 && m3_reg[0][1] == '0 && m3_reg[2][1] == '0, "zero rotation is not identity")
    // matrix entries leave clamped to [-1, 1]
    `RRM_ASSERT_NOW(a_mat_clamp, m_tvalid, mat_reg[0][0] <= ONE_Q30 && mat_reg[0][0] >= -ONE_Q30 && mat_reg[2][1] <= ONE_Q30 && mat_reg[2][1] >= -ONE_Q30, "matrix entry out of range")

endmodule
